@@ design/assert_macros.svh @@
// Assertion macros of the design, used by ccl_update.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Plain property check, disabled while reset is held
`define CCL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// Same-cycle implication check
`define CCL_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: check failed");
`else
`define CCL_ASSERT(label, clk, rst_n, prop)
`define CCL_ASSERT_IMPL(label, clk, rst_n, pre, post)
`endif
`endif

@@ design/ccl_pkg.sv @@
// Types and constants of the clock count launch gate.
package ccl_pkg;

    localparam int COUNT_W = 7;
    localparam int FADE_W  = 17;
    localparam int VOLT_W  = 16;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 17;

    localparam logic [FADE_W-1:0] FADE_UNITY = 17'd65536;

    // Register indexes of the configuration port
    typedef enum logic [IDX_W-1:0] {
        REG_COUNT_LIMIT    = 3'd0,
        REG_THRESHOLD_LOW  = 3'd1,
        REG_THRESHOLD_HIGH = 3'd2,
        REG_FADE_STEP      = 3'd3,
        REG_MUTE_ON_RESET  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic        [COUNT_W-1:0] count_limit;
        logic signed [VOLT_W-1:0]  threshold_low;
        logic signed [VOLT_W-1:0]  threshold_high;
        logic        [FADE_W-1:0]  fade_step;
        logic                      mute_on_reset;
    } t_cfg;

    // Trigger inputs of one sample
    typedef struct packed {
        logic signed [VOLT_W-1:0] clock_volts;
        logic signed [VOLT_W-1:0] reset_volts;
        logic                     reset_button;
    } t_trig_in;

    // State after one sample, carried to the scaling stage
    typedef struct packed {
        logic [COUNT_W-1:0] edge_count;
        logic               gate_is_open;
        logic [FADE_W-1:0]  fade_level;
    } t_status;

endpackage

@@ design/ccl_if.sv @@
// Channel interfaces: sample input, result output, configuration writes.
interface ccl_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                                    valid;
    logic                                    ready;
    logic signed [SAMPLE_BITS-1:0]           audio_in;
    logic signed [ccl_pkg::VOLT_W-1:0]       clock_volts;
    logic signed [ccl_pkg::VOLT_W-1:0]       reset_volts;
    logic                                    reset_button;

    modport source (output valid, audio_in, clock_volts, reset_volts, reset_button,
                    input ready);
    modport sink   (input valid, audio_in, clock_volts, reset_volts, reset_button,
                    output ready);
endinterface

interface ccl_result_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS-1:0]   audio_out;
    logic [ccl_pkg::COUNT_W-1:0]     edge_count;
    logic                            gate_is_open;
    logic [ccl_pkg::FADE_W-1:0]      fade_level;

    modport source (output valid, audio_out, edge_count, gate_is_open, fade_level,
                    input ready);
    modport sink   (input valid, audio_out, edge_count, gate_is_open, fade_level,
                    output ready);
endinterface

interface ccl_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ccl_pkg::IDX_W-1:0]   index;
    logic [ccl_pkg::DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/ccl_cfg_regs.sv @@
// Configuration register file of the launch gate.
module ccl_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ccl_cfg_if.sink       i_cfg,
    output ccl_pkg::t_cfg o_cfg
);

    ccl_pkg::t_cfg r_cfg;

    // Writes are always taken
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_limit    <= 7'd1;
            r_cfg.threshold_low  <= 16'sd0;
            r_cfg.threshold_high <= 16'sd1024;
            r_cfg.fade_step      <= 17'd66;
            r_cfg.mute_on_reset  <= 1'b1;
        end else if (i_cfg.valid) begin
            case (ccl_pkg::t_reg_idx'(i_cfg.index))
                ccl_pkg::REG_COUNT_LIMIT:    r_cfg.count_limit    <= i_cfg.data[6:0];
                ccl_pkg::REG_THRESHOLD_LOW:  r_cfg.threshold_low  <= $signed(i_cfg.data[15:0]);
                ccl_pkg::REG_THRESHOLD_HIGH: r_cfg.threshold_high <= $signed(i_cfg.data[15:0]);
                ccl_pkg::REG_FADE_STEP:      r_cfg.fade_step      <= i_cfg.data;
                ccl_pkg::REG_MUTE_ON_RESET:  r_cfg.mute_on_reset  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

endmodule

@@ design/ccl_update.sv @@
// Trigger, edge counter, gate latch and fade ramp state for one sample.
`include "assert_macros.svh"
module ccl_update #(
    parameter int COUNT_MAX = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccl_pkg::t_cfg     i_cfg,
    input  logic              i_fire,
    input  ccl_pkg::t_trig_in i_in,
    output ccl_pkg::t_status  o_status
);

    localparam logic [7:0] LIMIT_CAP = 8'(COUNT_MAX);

    // Triggers armed high at reset
    logic                        r_clk_hi, r_rst_hi, r_btn_hi;
    logic                        n_clk_hi, n_rst_hi, n_btn_hi;
    // One bit above the field so a count past the limit stays past it
    logic [7:0]                  r_count, n_count;
    logic                        r_gate, n_gate;
    logic [ccl_pkg::FADE_W-1:0]  r_fade, n_fade;
    logic [ccl_pkg::COUNT_W-1:0] w_limit;

    // Limit clamped to 1..COUNT_MAX
    always_comb begin
        if (i_cfg.count_limit == '0) begin
            w_limit = 7'd1;
        end else if ({1'b0, i_cfg.count_limit} > LIMIT_CAP) begin
            w_limit = LIMIT_CAP[6:0];
        end else begin
            w_limit = i_cfg.count_limit;
        end
    end

    // Next state for the sample in the input register
    always_comb begin
        logic                        btn_edge, rst_edge, clk_edge, reset_now;
        logic [ccl_pkg::FADE_W-1:0]  base;
        logic [ccl_pkg::FADE_W:0]    sum;

        n_btn_hi = r_btn_hi;
        n_rst_hi = r_rst_hi;
        n_clk_hi = r_clk_hi;
        btn_edge = 1'b0;
        rst_edge = 1'b0;
        clk_edge = 1'b0;

        // Button: low level 0, high level 1
        if (r_btn_hi) begin
            if (!i_in.reset_button) n_btn_hi = 1'b0;
        end else if (i_in.reset_button) begin
            n_btn_hi = 1'b1;
            btn_edge = 1'b1;
        end

        // External reset is skipped when the button already fired
        if (!btn_edge) begin
            if (r_rst_hi) begin
                if ($signed(i_in.reset_volts) <= $signed(i_cfg.threshold_low))
                    n_rst_hi = 1'b0;
            end else if ($signed(i_in.reset_volts) >= $signed(i_cfg.threshold_high)) begin
                n_rst_hi = 1'b1;
                rst_edge = 1'b1;
            end
        end
        reset_now = btn_edge | rst_edge;

        // Clock trigger holds on a reset sample
        if (!reset_now) begin
            if (r_clk_hi) begin
                if ($signed(i_in.clock_volts) <= $signed(i_cfg.threshold_low))
                    n_clk_hi = 1'b0;
            end else if ($signed(i_in.clock_volts) >= $signed(i_cfg.threshold_high)) begin
                n_clk_hi = 1'b1;
                clk_edge = 1'b1;
            end
        end

        // Counter and gate latch
        n_count = r_count;
        n_gate  = r_gate;
        if (reset_now) begin
            n_count = '0;
            n_gate  = 1'b0;
        end else if (clk_edge && (r_count <= {1'b0, w_limit}) && !r_gate) begin
            n_count = r_count + 8'd1;
        end
        if (n_count == {1'b0, w_limit}) n_gate = 1'b1;

        // Fade ramp, clamped to 0..unity
        base = (reset_now && i_cfg.mute_on_reset) ? '0 : r_fade;
        sum  = {1'b0, base} + {1'b0, i_cfg.fade_step};
        if (n_gate) begin
            n_fade = (sum > {1'b0, ccl_pkg::FADE_UNITY}) ? ccl_pkg::FADE_UNITY
                                                         : sum[ccl_pkg::FADE_W-1:0];
        end else begin
            n_fade = (base < i_cfg.fade_step) ? '0 : base - i_cfg.fade_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hi <= 1'b1;
            r_rst_hi <= 1'b1;
            r_btn_hi <= 1'b1;
            r_count  <= '0;
            r_gate   <= 1'b0;
            r_fade   <= '0;
        end else if (i_fire) begin
            r_clk_hi <= n_clk_hi;
            r_rst_hi <= n_rst_hi;
            r_btn_hi <= n_btn_hi;
            r_count  <= n_count;
            r_gate   <= n_gate;
            r_fade   <= n_fade;
        end
    end

    // State after the last sample is the result for it
    assign o_status.edge_count   = r_count[ccl_pkg::COUNT_W-1:0];
    assign o_status.gate_is_open = r_gate;
    assign o_status.fade_level   = r_fade;

    `CCL_ASSERT(a_fade_in_range, i_clk, i_rst_n, r_fade <= ccl_pkg::FADE_UNITY)
    `CCL_ASSERT(a_count_steps_by_one, i_clk, i_rst_n, r_count == $past(r_count) || r_count == $past(r_count) + 8'd1 || r_count == 8'd0)
    `CCL_ASSERT_IMPL(a_gate_opens_at_limit, i_clk, i_rst_n, $rose(r_gate), r_count == {1'b0, $past(w_limit)})
    `CCL_ASSERT_IMPL(a_idle_holds_state, i_clk, i_rst_n, !$past(i_fire) && $past(i_rst_n), $stable(r_count) && $stable(r_fade))

endmodule

@@ design/ccl_scale.sv @@
// Audio times fade gain, and the result register toward the output channel.
module ccl_scale #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_audio,
    input  ccl_pkg::t_status              i_status,
    output logic                          o_adv,
    ccl_result_if.source                  o_result
);

    logic signed [SAMPLE_BITS+17:0] w_prod;
    logic                           r_out_valid;
    logic signed [SAMPLE_BITS-1:0]  r_audio;
    ccl_pkg::t_status               r_status;

    // Pipeline moves when the result register is empty or being taken
    assign o_adv = !r_out_valid || o_result.ready;

    // Q16 gain, floor of the product over 65536
    assign w_prod = i_audio * $signed({1'b0, i_status.fade_level});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_valid) begin
            r_audio  <= w_prod[SAMPLE_BITS+15:16];
            r_status <= i_status;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.audio_out    = r_audio;
    assign o_result.edge_count   = r_status.edge_count;
    assign o_result.gate_is_open = r_status.gate_is_open;
    assign o_result.fade_level   = r_status.fade_level;

endmodule

@@ design/clock_count_launch_gate.sv @@
// Top level of the clock count launch gate.
//
//  port       dir  moves                          handshake
//  i_sample   in   audio, clock/reset volts, btn  valid/ready
//  o_result   out  audio, count, gate, fade       valid/ready
//  i_cfg      in   register index, write data     valid/ready, always ready
//
// One request per cycle unless o_result stalls; each request passes the stages below in order.
// Input register, then trigger/count/fade update, then the gain multiply
// into the result register; the update state feeds back from its own registers.
// i_rst_n is synchronous: triggers armed high, count, gate and fade cleared.
// A stalled result holds all three stages; i_sample.ready follows it.
module clock_count_launch_gate #(
    parameter int COUNT_MAX   = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ccl_sample_if.sink   i_sample,
    ccl_result_if.source o_result,
    ccl_cfg_if.sink      i_cfg
);

    ccl_pkg::t_cfg                 w_cfg;
    ccl_pkg::t_status              w_status;
    logic                          w_adv;
    logic                          w_fire;

    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_audio;
    ccl_pkg::t_trig_in             r_in_trig;
    logic                          r_mid_valid;
    logic signed [SAMPLE_BITS-1:0] r_mid_audio;

    assign i_sample.ready = w_adv;
    assign w_fire         = w_adv && r_in_valid;

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid  <= i_sample.valid;
            r_mid_valid <= r_in_valid;
        end
    end

    // Input register and audio delay alongside the update stage
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_audio             <= i_sample.audio_in;
            r_in_trig.clock_volts  <= i_sample.clock_volts;
            r_in_trig.reset_volts  <= i_sample.reset_volts;
            r_in_trig.reset_button <= i_sample.reset_button;
            r_mid_audio            <= r_in_audio;
        end
    end

    ccl_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    ccl_update #(
        .COUNT_MAX (COUNT_MAX)
    ) u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_fire   (w_fire),
        .i_in     (r_in_trig),
        .o_status (w_status)
    );

    ccl_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_mid_valid),
        .i_audio  (r_mid_audio),
        .i_status (w_status),
        .o_adv    (w_adv),
        .o_result (o_result)
    );

endmodule
